@@ rtl/siphash_pkg.sv @@
// Shared types and constants for the SipHash core.
package siphash_pkg;

   localparam int WORD_W      = 64;
   localparam int COUNT_W     = 4;
   localparam int LEN_W       = 8;
   localparam int ROUNDS_W    = 4;
   localparam int CSR_INDEX_W = 2;

   localparam logic [WORD_W-1:0] IV_ZERO  = 64'h736f6d6570736575;
   localparam logic [WORD_W-1:0] IV_ONE   = 64'h646f72616e646f6d;
   localparam logic [WORD_W-1:0] IV_TWO   = 64'h6c7967656e657261;
   localparam logic [WORD_W-1:0] IV_THREE = 64'h7465646279746573;
   localparam logic [WORD_W-1:0] FIN_CONST = 64'h00000000000000ff;

   localparam logic [COUNT_W-1:0]  FULL_COUNT   = 4'd8;
   localparam logic [LEN_W-1:0]    WORD_BYTES   = 8'd8;
   localparam logic [ROUNDS_W-1:0] RESET_CROUNDS = 4'd2;
   localparam logic [ROUNDS_W-1:0] RESET_DROUNDS = 4'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_FIRST   = 2'd0,
      CSR_KEY_SECOND  = 2'd1,
      CSR_COMP_ROUNDS = 2'd2,
      CSR_FIN_ROUNDS  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPRESS,
      ST_FINAL
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic round;
      logic mix;
      logic add_block;
      logic fin_xor;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic                item_last;
      logic                item_full;
      logic                out_free;
      logic [ROUNDS_W-1:0] comp_rounds;
      logic [ROUNDS_W-1:0] fin_rounds;
   } dp_status_type;

endpackage

@@ rtl/siphash_ctrl.sv @@
// Sequencer for the SipHash core: input transfer, round counting, emit.
module siphash_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  siphash_pkg::dp_status_type sts,
   output siphash_pkg::dp_cmd_type    cmd
);

   siphash_pkg::ctrl_state_type state_ff, state_in;
   logic [siphash_pkg::ROUNDS_W-1:0] rcnt_ff, rcnt_in;
   logic final_ff, final_in;
   logic pend_ff, pend_in;
   logic comp_end;
   logic fin_done;

   assign comp_end  = (sts.comp_rounds == '0) ||
                      (rcnt_ff == sts.comp_rounds - siphash_pkg::ROUNDS_W'(1));
   assign fin_done  = (rcnt_ff == sts.fin_rounds);
   assign req_stall = (state_ff != siphash_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         siphash_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = siphash_pkg::ST_COMPRESS;
            end
         end
         siphash_pkg::ST_COMPRESS: begin
            if (comp_end) begin
               if (final_ff) begin
                  state_in = siphash_pkg::ST_FINAL;
               end else if (!pend_ff) begin
                  state_in = siphash_pkg::ST_IDLE;
               end
            end
         end
         siphash_pkg::ST_FINAL: begin
            if (fin_done && sts.out_free) begin
               state_in = siphash_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = siphash_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd      = '0;
      rcnt_in  = rcnt_ff;
      final_in = final_ff;
      pend_in  = pend_ff;
      case (state_ff)
         siphash_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               rcnt_in    = '0;
               final_in   = sts.item_last && !sts.item_full;
               pend_in    = sts.item_last && sts.item_full;
            end
         end
         siphash_pkg::ST_COMPRESS: begin
            cmd.round = (sts.comp_rounds != '0);
            if (comp_end) begin
               cmd.mix = 1'b1;
               rcnt_in = '0;
               if (final_ff) begin
                  cmd.fin_xor = 1'b1;
               end else if (pend_ff) begin
                  // full last word done: load the length-only block
                  cmd.add_block = 1'b1;
                  final_in      = 1'b1;
                  pend_in       = 1'b0;
               end
            end else begin
               rcnt_in = rcnt_ff + siphash_pkg::ROUNDS_W'(1);
            end
         end
         siphash_pkg::ST_FINAL: begin
            if (!fin_done) begin
               cmd.round = 1'b1;
               rcnt_in   = rcnt_ff + siphash_pkg::ROUNDS_W'(1);
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
            end
         end
         default: begin
            rcnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= siphash_pkg::ST_IDLE;
         rcnt_ff  <= '0;
         final_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rcnt_ff  <= rcnt_in;
         final_ff <= final_in;
         pend_ff  <= pend_in;
      end
   end

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("hash emitted while output register is occupied");

   a_accept_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !(cmd.round || cmd.mix || cmd.emit || cmd.add_block))
      else $error("input transfer overlaps lane work");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> req_stall)
      else $error("sequencer did not go busy after input transfer");

   a_emit_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (state_ff == siphash_pkg::ST_IDLE))
      else $error("sequencer not idle after emit");

endmodule

@@ rtl/siphash_dp.sv @@
// Datapath of the SipHash core: lanes, keys, round unit, output register.
module siphash_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [siphash_pkg::WORD_W-1:0]        req_message_word,
   input  logic [siphash_pkg::COUNT_W-1:0]       req_byte_count,
   input  logic                                  req_last,
   input  logic                                  csr_valid,
   input  logic [siphash_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [siphash_pkg::WORD_W-1:0]        csr_data,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [siphash_pkg::WORD_W-1:0]        rsp_hash,
   input  siphash_pkg::dp_cmd_type               cmd,
   output siphash_pkg::dp_status_type            sts
);

   typedef struct packed {
      logic [siphash_pkg::WORD_W-1:0] v0;
      logic [siphash_pkg::WORD_W-1:0] v1;
      logic [siphash_pkg::WORD_W-1:0] v2;
      logic [siphash_pkg::WORD_W-1:0] v3;
   } lanes_type;

   function automatic lanes_type sip_round(input lanes_type v);
      logic [63:0] a0, a2, b1, b3, c0, c1, c2, c3;
      lanes_type r;
      a0 = v.v0 + v.v1;
      b1 = {v.v1[50:0], v.v1[63:51]} ^ a0;
      a2 = v.v2 + v.v3;
      b3 = {v.v3[47:0], v.v3[63:48]} ^ a2;
      c0 = {a0[31:0], a0[63:32]} + b3;
      c3 = {b3[42:0], b3[63:43]} ^ c0;
      c2 = a2 + b1;
      c1 = {b1[46:0], b1[63:47]} ^ c2;
      r.v0 = c0;
      r.v1 = c1;
      r.v2 = {c2[31:0], c2[63:32]};
      r.v3 = c3;
      return r;
   endfunction

   function automatic lanes_type key_lanes(input logic [63:0] k0, input logic [63:0] k1);
      lanes_type r;
      r.v0 = siphash_pkg::IV_ZERO ^ k0;
      r.v1 = siphash_pkg::IV_ONE ^ k1;
      r.v2 = siphash_pkg::IV_TWO ^ k0;
      r.v3 = siphash_pkg::IV_THREE ^ k1;
      return r;
   endfunction

   function automatic logic [63:0] mask_tail(input logic [63:0] w,
                                             input logic [siphash_pkg::COUNT_W-1:0] n);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (siphash_pkg::COUNT_W'(i) < n) begin
            r[8*i +: 8] = w[8*i +: 8];
         end
      end
      return r;
   endfunction

   lanes_type lanes_ff, lanes_in, rnd;
   logic [siphash_pkg::WORD_W-1:0]   key0_ff, key0_in, key1_ff, key1_in;
   logic [siphash_pkg::ROUNDS_W-1:0] crounds_ff, crounds_in, drounds_ff, drounds_in;
   logic [siphash_pkg::LEN_W-1:0]    len_ff, len_in, len_sum;
   logic [siphash_pkg::WORD_W-1:0]   msg_ff, msg_in;
   logic [siphash_pkg::WORD_W-1:0]   hash_ff, hash_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [siphash_pkg::WORD_W-1:0]   word_sel, final_blk, tail;
   logic                             full_word, key_write;

   assign sts.item_last   = req_last;
   assign sts.item_full   = (req_byte_count >= siphash_pkg::FULL_COUNT);
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;
   assign sts.comp_rounds = crounds_ff;
   assign sts.fin_rounds  = drounds_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash  = hash_ff;

   // a non-last word is always a full word; the count matters only on the last
   assign full_word = !req_last || sts.item_full;
   assign len_sum   = len_ff + (full_word ? siphash_pkg::WORD_BYTES
                                          : siphash_pkg::LEN_W'(req_byte_count));
   assign tail      = mask_tail(req_message_word, req_byte_count);
   assign word_sel  = full_word ? req_message_word : {len_sum, tail[55:0]};
   assign final_blk = {len_ff, 56'b0};

   always_comb begin
      key0_in    = key0_ff;
      key1_in    = key1_ff;
      crounds_in = crounds_ff;
      drounds_in = drounds_ff;
      key_write  = 1'b0;
      if (csr_valid) begin
         case (siphash_pkg::csr_index_type'(csr_index))
            siphash_pkg::CSR_KEY_FIRST: begin
               key0_in   = csr_data;
               key_write = 1'b1;
            end
            siphash_pkg::CSR_KEY_SECOND: begin
               key1_in   = csr_data;
               key_write = 1'b1;
            end
            siphash_pkg::CSR_COMP_ROUNDS: begin
               crounds_in = csr_data[siphash_pkg::ROUNDS_W-1:0];
            end
            siphash_pkg::CSR_FIN_ROUNDS: begin
               drounds_in = csr_data[siphash_pkg::ROUNDS_W-1:0];
            end
            default: begin
               key_write = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rnd          = cmd.round ? sip_round(lanes_ff) : lanes_ff;
      lanes_in     = rnd;
      msg_in       = msg_ff;
      len_in       = len_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.mix) begin
         lanes_in.v0 = rnd.v0 ^ msg_ff;
      end
      if (cmd.fin_xor) begin
         lanes_in.v2 = rnd.v2 ^ siphash_pkg::FIN_CONST;
      end
      if (cmd.add_block) begin
         lanes_in.v3 = rnd.v3 ^ final_blk;
         msg_in      = final_blk;
      end
      if (cmd.accept) begin
         lanes_in.v3 = lanes_ff.v3 ^ word_sel;
         msg_in      = word_sel;
         len_in      = len_sum;
      end
      if (cmd.emit) begin
         hash_in      = lanes_ff.v0 ^ lanes_ff.v1 ^ lanes_ff.v2 ^ lanes_ff.v3;
         rsp_valid_in = 1'b1;
         lanes_in     = key_lanes(key0_ff, key1_ff);
         len_in       = '0;
      end
      if (key_write) begin
         lanes_in = key_lanes(key0_in, key1_in);
         len_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lanes_ff     <= key_lanes('0, '0);
         key0_ff      <= '0;
         key1_ff      <= '0;
         crounds_ff   <= siphash_pkg::RESET_CROUNDS;
         drounds_ff   <= siphash_pkg::RESET_DROUNDS;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lanes_ff     <= lanes_in;
         key0_ff      <= key0_in;
         key1_ff      <= key1_in;
         crounds_ff   <= crounds_in;
         drounds_ff   <= drounds_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff  <= msg_in;
      hash_ff <= hash_in;
   end

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emit did not raise the result valid");

   a_emit_reloads_len: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (len_ff == '0))
      else $error("length not cleared after emit");

   a_valid_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && !cmd.emit) |=> ($stable(hash_ff) && rsp_valid_ff))
      else $error("held result changed");

endmodule

@@ rtl/siphash_keyed_hash_core.sv @@
// Top level of the keyed SipHash core: sequencer, datapath and register port.
// A non-last word is accepted, then compressed with C rounds, C = compression rounds.
// A last word is compressed the same way [plus a length-only block if it is full], then takes D rounds
// and the emit, which waits for the output register, D = finalization rounds.
// Throughput is set by the single SipRound unit: one round per cycle, one item at a time.
// Synchronous active-high reset: keys zero, C = 2, D = 4, lanes at the IV, no result held.
module siphash_keyed_hash_core (
   input  logic                                clock,
   input  logic                                reset,
   // message word channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [siphash_pkg::WORD_W-1:0]      req_message_word,
   input  logic [siphash_pkg::COUNT_W-1:0]     req_byte_count,
   input  logic                                req_last,
   // hash result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [siphash_pkg::WORD_W-1:0]      rsp_hash,
   // register write port
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [siphash_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [siphash_pkg::WORD_W-1:0]      csr_data
);

   siphash_pkg::dp_cmd_type    cmd;
   siphash_pkg::dp_status_type sts;

   // A key write reloads the lanes from the new keys and clears the length, also mid-message;
   // a round count write applies to the rounds still to run, also within a block.
   assign csr_ready = 1'b1;

   // The sequencer owns the round counter and the message phase; it issues
   // one command set per cycle to the datapath.
   siphash_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the four lanes, the length byte, keys, round counts
   // and the result register, which frees the input side while a hash waits
   // for its transfer.
   siphash_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_message_word (req_message_word),
      .req_byte_count   (req_byte_count),
      .req_last         (req_last),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_hash         (rsp_hash),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule
